// File: src/adsr_pkg.sv
package adsr_pkg;

  localparam int TIME_BITS   = 32;
  localparam int LEVEL_BITS  = 16;
  localparam int DUR_BITS    = 24;
  localparam int CFG_BITS    = (DUR_BITS > LEVEL_BITS) ? DUR_BITS : LEVEL_BITS;
  localparam int CMP_BITS    = (TIME_BITS > DUR_BITS + 1) ? TIME_BITS : DUR_BITS + 1;
  localparam int PROD_BITS   = DUR_BITS + LEVEL_BITS;
  localparam int DIV_STEPS   = LEVEL_BITS;
  localparam int FLOOR_LEVEL = (2 ** LEVEL_BITS) / 100;

  typedef enum logic [2:0] {
    REG_ATTACK_LEVEL  = 3'd0,
    REG_ATTACK_TIME   = 3'd1,
    REG_DECAY_TIME    = 3'd2,
    REG_SUSTAIN_LEVEL = 3'd3,
    REG_RELEASE_TIME  = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_ATTACK  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] current_time;
    logic [TIME_BITS-1:0] note_on_time;
    logic [TIME_BITS-1:0] note_off_time;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] envelope_level;
    phase_t                phase;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] attack_level;
    logic [DUR_BITS-1:0]   attack_time;
    logic [DUR_BITS-1:0]   decay_time;
    logic [LEVEL_BITS-1:0] sustain_level;
    logic [DUR_BITS-1:0]   release_time;
  } cfg_t;

  typedef struct packed {
    logic                  held_note;
    phase_t                ph;
    logic                  a_zero;
    logic                  neg;
    logic                  r_ge;
    logic [DUR_BITS-1:0]   r;
    logic [LEVEL_BITS-1:0] lvl;
  } side_t;

endpackage

// File: src/adsr_div.sv
module adsr_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [adsr_pkg::PROD_BITS-1:0] num,
  input  logic [adsr_pkg::DUR_BITS-1:0]  den,
  input  adsr_pkg::side_t                side_in,
  output logic                           out_valid,
  output logic [adsr_pkg::LEVEL_BITS-1:0] quo,
  output adsr_pkg::side_t                side_out
);
  import adsr_pkg::*;

  logic                  v    [0:DIV_STEPS-1];
  logic [DUR_BITS-1:0]   rem  [0:DIV_STEPS-1];
  logic [LEVEL_BITS-1:0] low  [0:DIV_STEPS-1];
  logic [LEVEL_BITS-1:0] q    [0:DIV_STEPS-1];
  logic [DUR_BITS-1:0]   dv   [0:DIV_STEPS-1];
  side_t                 sd   [0:DIV_STEPS-1];

  genvar i;
  generate
    for (i = 0; i < DIV_STEPS; i++) begin : g_step
      logic                  cv;
      logic [DUR_BITS-1:0]   crem;
      logic [LEVEL_BITS-1:0] clow;
      logic [LEVEL_BITS-1:0] cq;
      logic [DUR_BITS-1:0]   cd;
      side_t                 cs;
      logic [DUR_BITS:0]     t;
      logic                  ge;

      if (i == 0) begin : g_first
        assign cv   = in_valid;
        assign crem = num[PROD_BITS-1:LEVEL_BITS];
        assign clow = num[LEVEL_BITS-1:0];
        assign cq   = '0;
        assign cd   = den;
        assign cs   = side_in;
      end else begin : g_next
        assign cv   = v[i-1];
        assign crem = rem[i-1];
        assign clow = low[i-1];
        assign cq   = q[i-1];
        assign cd   = dv[i-1];
        assign cs   = sd[i-1];
      end

      assign t  = {crem, clow[LEVEL_BITS-1]};
      assign ge = t >= {1'b0, cd};

      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (en) begin
          v[i] <= cv;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= ge ? DUR_BITS'(t - {1'b0, cd}) : t[DUR_BITS-1:0];
          low[i] <= {clow[LEVEL_BITS-2:0], 1'b0};
          q[i]   <= {cq[LEVEL_BITS-2:0], ge};
          dv[i]  <= cd;
          sd[i]  <= cs;
        end
      end
    end
  endgenerate

  assign out_valid = v[DIV_STEPS-1];
  assign quo       = q[DIV_STEPS-1];
  assign side_out  = sd[DIV_STEPS-1];

endmodule

// File: src/adsr_front.sv
module adsr_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  adsr_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  input  adsr_pkg::in_item_t             in_item,
  output logic                           out_valid,
  output logic [adsr_pkg::PROD_BITS-1:0] num,
  output logic [adsr_pkg::DUR_BITS-1:0]  den,
  output adsr_pkg::side_t                side
);
  import adsr_pkg::*;

  logic                 a_valid;
  logic [TIME_BITS-1:0] a_life;
  logic [TIME_BITS-1:0] a_r;
  logic                 a_held;

  logic                 b_valid;
  logic                 b_held;
  phase_t               b_ph;
  logic                 b_a_zero;
  logic                 b_r_ge;
  logic [DUR_BITS-1:0]  b_x;
  logic [DUR_BITS-1:0]  b_r;

  logic [CMP_BITS-1:0]  life_w, r_w, a_w, ad_w, rt_w;
  phase_t               ph_next;
  logic [LEVEL_BITS-1:0] mag;
  logic                 neg;

  // stage A: elapsed times
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_held <= in_item.note_on_time > in_item.note_off_time;
      if (in_item.note_on_time > in_item.note_off_time) begin
        a_life <= (in_item.current_time > in_item.note_on_time) ?
                  in_item.current_time - in_item.note_on_time : '0;
      end else begin
        a_life <= in_item.note_off_time - in_item.note_on_time;
      end
      a_r <= (in_item.current_time > in_item.note_off_time) ?
             in_item.current_time - in_item.note_off_time : '0;
    end
  end

  // stage B: phase select
  always_comb begin
    life_w = CMP_BITS'(a_life);
    r_w    = CMP_BITS'(a_r);
    a_w    = CMP_BITS'(cfg.attack_time);
    ad_w   = CMP_BITS'(cfg.attack_time) + CMP_BITS'(cfg.decay_time);
    rt_w   = CMP_BITS'(cfg.release_time);
    if (life_w <= a_w) begin
      ph_next = PH_ATTACK;
    end else if (life_w <= ad_w) begin
      ph_next = PH_DECAY;
    end else begin
      ph_next = PH_SUSTAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_held   <= a_held;
      b_ph     <= ph_next;
      b_a_zero <= cfg.attack_time == '0;
      b_r_ge   <= r_w >= rt_w;
      b_r      <= a_r[DUR_BITS-1:0];
      b_x      <= (ph_next == PH_ATTACK) ? life_w[DUR_BITS-1:0] :
                  DUR_BITS'(life_w - a_w);
    end
  end

  // stage C: numerator product
  always_comb begin
    neg = cfg.sustain_level < cfg.attack_level;
    if (b_ph == PH_ATTACK) begin
      mag = cfg.attack_level;
    end else if (neg) begin
      mag = cfg.attack_level - cfg.sustain_level;
    end else begin
      mag = cfg.sustain_level - cfg.attack_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num         <= PROD_BITS'(b_x) * PROD_BITS'(mag);
      den         <= (b_ph == PH_ATTACK) ? cfg.attack_time : cfg.decay_time;
      side.held_note <= b_held;
      side.ph     <= b_ph;
      side.a_zero <= b_a_zero;
      side.neg    <= neg;
      side.r_ge   <= b_r_ge;
      side.r      <= b_r;
      side.lvl    <= '0;
    end
  end

endmodule

// File: src/adsr_back.sv
module adsr_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  adsr_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  input  logic [adsr_pkg::LEVEL_BITS-1:0] quo,
  input  adsr_pkg::side_t                 side_in,
  output logic                            out_valid,
  output logic [adsr_pkg::PROD_BITS-1:0]  num,
  output logic [adsr_pkg::DUR_BITS-1:0]   den,
  output adsr_pkg::side_t                 side_out
);
  import adsr_pkg::*;

  logic                  d_valid;
  side_t                 d_side;
  side_t                 d_side_next;
  logic [LEVEL_BITS-1:0] lvl;

  // stage D: held level
  always_comb begin
    unique case (side_in.ph)
      PH_ATTACK:  lvl = side_in.a_zero ? cfg.attack_level : quo;
      PH_DECAY:   lvl = side_in.neg ? cfg.attack_level - quo : cfg.attack_level + quo;
      PH_SUSTAIN: lvl = cfg.sustain_level;
      default:    lvl = cfg.sustain_level;
    endcase
  end

  always_comb begin
    d_side_next     = side_in;
    d_side_next.lvl = lvl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side <= d_side_next;
    end
  end

  // stage E: release product
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num      <= PROD_BITS'(d_side.r) * PROD_BITS'(d_side.lvl);
      den      <= cfg.release_time;
      side_out <= d_side;
    end
  end

endmodule

// File: src/adsr_envelope_amplitude_core.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_item  (current, note-on, note-off time)
// out      output     out_valid / out_stall  out_item (envelope_level, phase)
// cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; two bit-per-stage
// dividers of LEVEL_BITS stages each sit among six other stages.
// Synchronous reset clears valid bits and loads register defaults.
// out_stall on a valid output holds every stage at once; in_stall is high exactly while the
// output holds an item that is stalled.
module adsr_envelope_amplitude_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  adsr_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output adsr_pkg::out_item_t           out_item,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [adsr_pkg::CFG_BITS-1:0] cfg_data
);
  import adsr_pkg::*;

  cfg_t                  cfg;
  logic                  en;

  logic                  f_valid;
  logic [PROD_BITS-1:0]  f_num;
  logic [DUR_BITS-1:0]   f_den;
  side_t                 f_side;

  logic                  d1_valid;
  logic [LEVEL_BITS-1:0] d1_quo;
  side_t                 d1_side;

  logic                  b_valid;
  logic [PROD_BITS-1:0]  b_num;
  logic [DUR_BITS-1:0]   b_den;
  side_t                 b_side;

  logic                  d2_valid;
  logic [LEVEL_BITS-1:0] d2_quo;
  side_t                 d2_side;

  logic [LEVEL_BITS-1:0] level;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_level  <= LEVEL_BITS'(65535);
      cfg.attack_time   <= DUR_BITS'(4800);
      cfg.decay_time    <= DUR_BITS'(4800);
      cfg.sustain_level <= LEVEL_BITS'(52428);
      cfg.release_time  <= DUR_BITS'(9600);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK_LEVEL:  cfg.attack_level  <= cfg_data[LEVEL_BITS-1:0];
        REG_ATTACK_TIME:   cfg.attack_time   <= cfg_data[DUR_BITS-1:0];
        REG_DECAY_TIME:    cfg.decay_time    <= cfg_data[DUR_BITS-1:0];
        REG_SUSTAIN_LEVEL: cfg.sustain_level <= cfg_data[LEVEL_BITS-1:0];
        REG_RELEASE_TIME:  cfg.release_time  <= cfg_data[DUR_BITS-1:0];
        default: ;
      endcase
    end
  end

  adsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .out_valid (f_valid),
    .num       (f_num),
    .den       (f_den),
    .side      (f_side)
  );

  adsr_div u_div_held (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num       (f_num),
    .den       (f_den),
    .side_in   (f_side),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .side_out  (d1_side)
  );

  adsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (d1_valid),
    .quo       (d1_quo),
    .side_in   (d1_side),
    .out_valid (b_valid),
    .num       (b_num),
    .den       (b_den),
    .side_out  (b_side)
  );

  adsr_div u_div_rel (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .num       (b_num),
    .den       (b_den),
    .side_in   (b_side),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .side_out  (d2_side)
  );

  always_comb begin
    if (d2_side.held_note) begin
      level = d2_side.lvl;
    end else if (d2_side.r_ge) begin
      level = '0;
    end else begin
      level = d2_side.lvl - d2_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.envelope_level <= (level <= LEVEL_BITS'(FLOOR_LEVEL)) ? '0 : level;
      out_item.phase          <= d2_side.held_note ? d2_side.ph : PH_RELEASE;
    end
  end

endmodule
